/* sv/run_delta_chunk_encoder_assert.svh */
// Assertion macros used by the checker of this block.
// Each macro samples on the rising edge of clk and is off while rst is high.
`ifndef RUN_DELTA_CHUNK_ENCODER_ASSERT_SVH
`define RUN_DELTA_CHUNK_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define RDCE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdce assertion failed");

// Next-cycle implication.
`define RDCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdce assertion failed");

`endif

/* sv/rdce_pkg.sv */
package rdce_pkg;

  localparam int LenWidth   = 14;
  localparam int ValWidth   = 8;
  localparam int CountWidth = 3;

  // Longest accepted run; longer runs are flagged and dropped.
  localparam logic [LenWidth-1:0] MAX_RUN     = 14'd8191;
  // Delta runs are cut into pieces of at most this many pixels.
  localparam logic [LenWidth-1:0] DELTA_SPLIT = 14'd255;

  // Length thresholds for the number of high length bytes.
  localparam logic [LenWidth-1:0] LEN_NIBBLE_MAX = 14'h000F;
  localparam logic [LenWidth-1:0] LEN_ONE_MAX    = 14'h0FFF;

  // Delta window around the previous value.
  localparam logic [ValWidth:0] DELTA_RANGE = 9'd15;

  // Gray levels with their own chunk types.
  localparam logic [ValWidth-1:0] VAL_BLACK = 8'h00;
  localparam logic [ValWidth-1:0] VAL_WHITE = 8'hFF;

  // Chunk type codes (top two bits of the first byte).
  localparam logic [1:0] TYPE_BLACK = 2'd0;
  localparam logic [1:0] TYPE_VALUE = 2'd1;
  localparam logic [1:0] TYPE_DELTA = 2'b10;
  localparam logic [1:0] TYPE_WHITE = 2'd3;

  // Number of high length bytes.
  localparam logic [1:0] LSIZE_NONE = 2'd0;
  localparam logic [1:0] LSIZE_ONE  = 2'd1;
  localparam logic [1:0] LSIZE_TWO  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // take the accepted run into the work registers
    logic emit;   // produce one chunk into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic len_nonzero;  // the offered run has a nonzero length
    logic out_free;     // output register can take a chunk this cycle
    logic final_chunk;  // the chunk being built ends the current run
  } stat_t;

endpackage

/* sv/rdce_if.sv */
// Run request channel.
interface rdce_run_if;
  logic                             valid;
  logic                             ready;
  logic [rdce_pkg::LenWidth-1:0]    run_length;
  logic [rdce_pkg::ValWidth-1:0]    pixel_value;

  modport source (output valid, output run_length, output pixel_value, input ready);
  modport sink   (input valid, input run_length, input pixel_value, output ready);
endinterface

// Chunk request channel.
interface rdce_chunk_if;
  logic                             valid;
  logic                             ready;
  logic [7:0]                       chunk_byte0;
  logic [7:0]                       chunk_byte1;
  logic [7:0]                       chunk_byte2;
  logic [7:0]                       chunk_byte3;
  logic [rdce_pkg::CountWidth-1:0]  byte_count;
  logic                             last_chunk;
  logic                             rejected;

  modport source (output valid, output chunk_byte0, output chunk_byte1,
                  output chunk_byte2, output chunk_byte3, output byte_count,
                  output last_chunk, output rejected, input ready);
  modport sink   (input valid, input chunk_byte0, input chunk_byte1,
                  input chunk_byte2, input chunk_byte3, input byte_count,
                  input last_chunk, input rejected, output ready);
endinterface

/* sv/run_delta_chunk_encoder.sv */
// A taken run is loaded into the work registers; its first chunk enters the output register once that is free.
// Throughput: one chunk per cycle while the sink is ready; a run is loaded and then
// coded as one chunk, or up to 33 chunks for long delta runs,
// by the single chunk builder the controller steps through the run.
// A zero-length run is taken and gives nothing.
// Reset (rst, synchronous): controller idle, output empty, previous value 0.
module run_delta_chunk_encoder #(
  parameter logic [rdce_pkg::LenWidth-1:0] MAX_RUN = rdce_pkg::MAX_RUN
) (
  input  logic         clk,
  input  logic         rst,
  rdce_run_if.sink     run_in,
  rdce_chunk_if.source chunk_out
);

  rdce_pkg::cmd_t  cmd;
  rdce_pkg::stat_t stat;

  rdce_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (run_in.valid),
    .in_ready (run_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rdce_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .run_length  (run_in.run_length),
    .pixel_value (run_in.pixel_value),
    .out_ready   (chunk_out.ready),
    .out_valid   (chunk_out.valid),
    .chunk_byte0 (chunk_out.chunk_byte0),
    .chunk_byte1 (chunk_out.chunk_byte1),
    .chunk_byte2 (chunk_out.chunk_byte2),
    .chunk_byte3 (chunk_out.chunk_byte3),
    .byte_count  (chunk_out.byte_count),
    .last_chunk  (chunk_out.last_chunk),
    .rejected    (chunk_out.rejected)
  );

endmodule

/* sv/rdce_datapath.sv */
module rdce_datapath #(
  parameter logic [rdce_pkg::LenWidth-1:0] MAX_RUN = rdce_pkg::MAX_RUN
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rdce_pkg::cmd_t                  cmd,
  output rdce_pkg::stat_t                 stat,
  input  logic [rdce_pkg::LenWidth-1:0]   run_length,
  input  logic [rdce_pkg::ValWidth-1:0]   pixel_value,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [7:0]                      chunk_byte0,
  output logic [7:0]                      chunk_byte1,
  output logic [7:0]                      chunk_byte2,
  output logic [7:0]                      chunk_byte3,
  output logic [rdce_pkg::CountWidth-1:0] byte_count,
  output logic                            last_chunk,
  output logic                            rejected
);

  // Work registers for the run being coded
  logic [rdce_pkg::LenWidth-1:0] remaining;
  logic [rdce_pkg::ValWidth-1:0] value;
  logic                          reject_run;

  // Coder state kept across runs
  logic [rdce_pkg::ValWidth-1:0] previous_value;
  logic                          any_emitted;

  // Chunk under construction
  logic signed [rdce_pkg::ValWidth:0] diff;
  logic        [rdce_pkg::ValWidth:0] mag;
  logic                               is_delta;
  logic [rdce_pkg::LenWidth-1:0]      piece;
  logic [1:0]                         ctype;
  logic [1:0]                         lsize;
  logic [7:0]                         b0, b1, b2, b3;
  logic [rdce_pkg::CountWidth-1:0]    count;

  assign stat.len_nonzero = (run_length != '0);
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.final_chunk = reject_run || (piece == remaining);

  // Delta decision against the previous value
  always_comb begin
    diff = $signed({1'b0, value}) - $signed({1'b0, previous_value});
    mag  = diff[rdce_pkg::ValWidth] ? 9'(-diff) : 9'(diff);
    is_delta = (value != rdce_pkg::VAL_BLACK) && (value != rdce_pkg::VAL_WHITE) &&
               any_emitted && (mag <= rdce_pkg::DELTA_RANGE);
  end

  // Piece length and chunk bytes
  always_comb begin
    ctype = rdce_pkg::TYPE_VALUE;
    if (value == rdce_pkg::VAL_BLACK) begin
      ctype = rdce_pkg::TYPE_BLACK;
    end else if (value == rdce_pkg::VAL_WHITE) begin
      ctype = rdce_pkg::TYPE_WHITE;
    end
    if (remaining <= rdce_pkg::LEN_NIBBLE_MAX) begin
      lsize = rdce_pkg::LSIZE_NONE;
    end else if (remaining <= rdce_pkg::LEN_ONE_MAX) begin
      lsize = rdce_pkg::LSIZE_ONE;
    end else begin
      lsize = rdce_pkg::LSIZE_TWO;
    end
    b0 = '0;
    b1 = '0;
    b2 = '0;
    b3 = '0;
    count = 3'd1;
    piece = remaining;
    if (is_delta) begin
      if (remaining > rdce_pkg::DELTA_SPLIT) begin
        piece = rdce_pkg::DELTA_SPLIT;
      end
      b0 = {rdce_pkg::TYPE_DELTA, diff[rdce_pkg::ValWidth], piece != 14'd1, mag[3:0]};
      if (piece != 14'd1) begin
        b1 = piece[7:0];
        count = 3'd2;
      end
    end else begin
      b0 = {ctype, lsize, remaining[3:0]};
      // value byte first for the general type, then high length bytes
      if (ctype == rdce_pkg::TYPE_VALUE) begin
        b1 = value;
        case (lsize)
          rdce_pkg::LSIZE_NONE: count = 3'd2;
          rdce_pkg::LSIZE_ONE: begin
            b2 = remaining[11:4];
            count = 3'd3;
          end
          default: begin
            b2 = {6'd0, remaining[13:12]};
            b3 = remaining[11:4];
            count = 3'd4;
          end
        endcase
      end else begin
        case (lsize)
          rdce_pkg::LSIZE_NONE: count = 3'd1;
          rdce_pkg::LSIZE_ONE: begin
            b1 = remaining[11:4];
            count = 3'd2;
          end
          default: begin
            b1 = {6'd0, remaining[13:12]};
            b2 = remaining[11:4];
            count = 3'd3;
          end
        endcase
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remaining  <= run_length;
      value      <= pixel_value;
      reject_run <= (run_length > MAX_RUN);
    end else if (cmd.emit && !reject_run) begin
      remaining <= remaining - piece;
    end
  end

  // Previous value and started flag
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value <= '0;
      any_emitted    <= 1'b0;
    end else if (cmd.emit && !reject_run) begin
      previous_value <= value;
      any_emitted    <= 1'b1;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (reject_run) begin
        chunk_byte0 <= '0;
        chunk_byte1 <= '0;
        chunk_byte2 <= '0;
        chunk_byte3 <= '0;
        byte_count  <= '0;
        last_chunk  <= 1'b1;
        rejected    <= 1'b1;
      end else begin
        chunk_byte0 <= b0;
        chunk_byte1 <= b1;
        chunk_byte2 <= b2;
        chunk_byte3 <= b3;
        byte_count  <= count;
        last_chunk  <= (piece == remaining);
        rejected    <= 1'b0;
      end
    end
  end

endmodule

/* sv/rdce_controller.sv */
module rdce_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rdce_pkg::stat_t stat,
  output rdce_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign in_ready = (state == ST_IDLE);

  // Commands
  always_comb begin
    cmd.load = (state == ST_IDLE) && in_valid && stat.len_nonzero;
    cmd.emit = (state == ST_RUN) && stat.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.emit && stat.final_chunk) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/rdce_checker.sv */
`include "run_delta_chunk_encoder_assert.svh"

module rdce_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [rdce_pkg::LenWidth-1:0]   run_length,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [7:0]                      chunk_byte1,
  input logic [7:0]                      chunk_byte2,
  input logic [7:0]                      chunk_byte3,
  input logic [rdce_pkg::CountWidth-1:0] byte_count,
  input logic                            last_chunk,
  input logic                            rejected
);

  // A rejected run shows as one empty, final result
  `RDCE_ASSERT_NOW(a_reject_empty, out_valid && rejected, byte_count == '0 && last_chunk)

  // Encoded chunks hold one to four bytes
  `RDCE_ASSERT_NOW(a_count_range, out_valid && !rejected, byte_count != '0 && byte_count <= 3'd4)

  // Single-byte results have their other bytes zero
  `RDCE_ASSERT_NOW(a_tail_zero, out_valid && byte_count == 3'd1,
                   chunk_byte1 == '0 && chunk_byte2 == '0 && chunk_byte3 == '0)

  // A taken nonempty run is followed by ready low
  `RDCE_ASSERT_NEXT(a_one_run_at_a_time, in_valid && in_ready && run_length != '0, !in_ready)

  // A stalled result stays put
  `RDCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(byte_count) && $stable(last_chunk))

endmodule

bind run_delta_chunk_encoder rdce_checker u_rdce_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (run_in.valid),
  .in_ready    (run_in.ready),
  .run_length  (run_in.run_length),
  .out_valid   (chunk_out.valid),
  .out_ready   (chunk_out.ready),
  .chunk_byte1 (chunk_out.chunk_byte1),
  .chunk_byte2 (chunk_out.chunk_byte2),
  .chunk_byte3 (chunk_out.chunk_byte3),
  .byte_count  (chunk_out.byte_count),
  .last_chunk  (chunk_out.last_chunk),
  .rejected    (chunk_out.rejected)
);

/* tb/tb_run_delta_chunk_encoder.sv */
`timescale 1ns / 1ps

module tb_run_delta_chunk_encoder;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 84;
  localparam int MAX_SHOWN = 30;

  typedef struct {
    logic [rdce_pkg::LenWidth-1:0] len;
    logic [rdce_pkg::ValWidth-1:0] gray;
  } run_t;

  typedef struct packed {
    logic [7:0]                      b0;
    logic [7:0]                      b1;
    logic [7:0]                      b2;
    logic [7:0]                      b3;
    logic [rdce_pkg::CountWidth-1:0] count;
    logic                            is_last;
    logic                            is_rej;
  } chunk_t;

  logic clk = 1'b0;
  logic rst;

  rdce_run_if   run_if();
  rdce_chunk_if chunk_if();

  run_delta_chunk_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .run_in    (run_if),
    .chunk_out (chunk_if)
  );

  // Run requests waiting to go out, chunks the encoder still owes us.
  run_t   runs_to_send[$];
  chunk_t chunks_due[$];
  run_t   next_run;

  // Encoder state as the predictor sees it.
  logic [rdce_pkg::ValWidth-1:0] last_gray = '0;
  logic                          coded_any = 1'b0;

  // Last value handed to the generator, used to aim at the delta window.
  int gen_gray;

  int idle_pct;
  int stall_pct;
  int errors = 0;
  int runs_taken = 0;
  int chunks_checked = 0;
  int delta_chunks = 0;
  int rejects_due = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  // Append one predicted chunk.
  function automatic void owe_chunk(input chunk_t c);
    chunks_due = {chunks_due, c};
  endfunction

  // Chunks that one accepted run should produce.
  function automatic void encode_run(input logic [rdce_pkg::LenWidth-1:0] len,
                                     input logic [rdce_pkg::ValWidth-1:0] gray);
    logic [rdce_pkg::LenWidth-1:0] left;
    logic [rdce_pkg::LenWidth-1:0] piece;
    logic [19:0]                   wide;
    logic [1:0]                    kind;
    logic [1:0]                    lsize;
    logic [7:0]                    bytes [4];
    int                            diff;
    int                            mag;
    int                            n;
    chunk_t                        c;

    if (len == 0) return;
    if (len > rdce_pkg::MAX_RUN) begin
      c = '0;
      c.is_last = 1'b1;
      c.is_rej = 1'b1;
      owe_chunk(c);
      rejects_due++;
      return;
    end
    left = len;
    while (left != 0) begin
      diff = int'(gray) - int'(last_gray);
      mag = (diff < 0) ? -diff : diff;
      bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
      if (gray != rdce_pkg::VAL_BLACK && gray != rdce_pkg::VAL_WHITE && coded_any &&
          mag <= int'(rdce_pkg::DELTA_RANGE)) begin
        // delta piece, at most DELTA_SPLIT pixels
        piece = (left > rdce_pkg::DELTA_SPLIT) ? rdce_pkg::DELTA_SPLIT : left;
        bytes[0] = {rdce_pkg::TYPE_DELTA, diff < 0, piece != 1, 4'(mag)};
        n = 1;
        if (piece != 1) begin
          bytes[1] = piece[7:0];
          n = 2;
        end
        delta_chunks++;
      end else begin
        // black / white / literal value, whole remaining length
        kind = (gray == rdce_pkg::VAL_BLACK) ? rdce_pkg::TYPE_BLACK :
               (gray == rdce_pkg::VAL_WHITE) ? rdce_pkg::TYPE_WHITE : rdce_pkg::TYPE_VALUE;
        lsize = (left <= rdce_pkg::LEN_NIBBLE_MAX) ? rdce_pkg::LSIZE_NONE :
                (left <= rdce_pkg::LEN_ONE_MAX) ? rdce_pkg::LSIZE_ONE : rdce_pkg::LSIZE_TWO;
        piece = left;
        wide = 20'(left);
        bytes[0] = {kind, lsize, wide[3:0]};
        n = 1;
        if (kind == rdce_pkg::TYPE_VALUE) begin
          bytes[n] = gray;
          n++;
        end
        if (lsize == rdce_pkg::LSIZE_ONE) begin
          bytes[n] = wide[11:4];
          n++;
        end else if (lsize == rdce_pkg::LSIZE_TWO) begin
          bytes[n] = wide[19:12];
          bytes[n+1] = wide[11:4];
          n += 2;
        end
      end
      left = left - piece;
      last_gray = gray;
      coded_any = 1'b1;
      c.b0 = bytes[0];
      c.b1 = bytes[1];
      c.b2 = bytes[2];
      c.b3 = bytes[3];
      c.count = n[rdce_pkg::CountWidth-1:0];
      c.is_last = (left == 0);
      c.is_rej = 1'b0;
      owe_chunk(c);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  function automatic void add_run(input int len, input int gray);
    run_t r;
    r.len = len[rdce_pkg::LenWidth-1:0];
    r.gray = gray[rdce_pkg::ValWidth-1:0];
    if (r.len != 0 && r.len <= rdce_pkg::MAX_RUN) gen_gray = gray;
    runs_to_send = {runs_to_send, r};
  endfunction

  // Close to half the runs near the last value so deltas show up, plus the other kinds.
  task automatic queue_random(input int n);
    int pick;
    int g;
    int len;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        g = gen_gray + $urandom_range(0, 30) - 15;
        if (g < 0) g = 0;
        if (g > 255) g = 255;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 700) : $urandom_range(1, 20);
      end else if (pick < 60) begin
        g = $urandom_range(0, 1) ? 255 : 0;
        len = $urandom_range(1, 300);
      end else if (pick < 80) begin
        g = $urandom_range(0, 255);
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(4096, 8191);
          1, 2, 3: len = $urandom_range(16, 4095);
          default: len = $urandom_range(1, 15);
        endcase
      end else if (pick < 88) begin
        g = $urandom_range(0, 255);
        len = 0;
      end else if (pick < 94) begin
        g = $urandom_range(0, 255);
        len = $urandom_range(8192, 16383);
      end else begin
        g = $urandom_range(0, 255);
        len = $urandom_range(0, 16383);
      end
      add_run(len, g);
    end
  endtask

  // Hold off until every run has been taken and every chunk has come back.
  task automatic drain;
    while (runs_to_send.size() != 0 || run_if.valid) @(negedge clk);
    while (chunks_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Run request driver
  always @(posedge clk) begin
    if (rst) begin
      run_if.valid <= 1'b0;
      run_if.run_length <= '0;
      run_if.pixel_value <= '0;
    end else begin
      if (run_if.valid && run_if.ready) begin
        encode_run(run_if.run_length, run_if.pixel_value);
        runs_taken++;
      end
      if (!run_if.valid || run_if.ready) begin
        if (runs_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_run = runs_to_send.pop_front();
          run_if.valid <= 1'b1;
          run_if.run_length <= next_run.len;
          run_if.pixel_value <= next_run.gray;
        end else begin
          run_if.valid <= 1'b0;
        end
      end
    end
  end

  // Chunk monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      chunk_if.ready <= 1'b0;
    end else begin
      if (chunk_if.valid && chunk_if.ready) begin
        if (chunks_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected chunk, expected none actual %h %h %h %h cnt %0d last %b rej %b",
                   $time, chunk_if.chunk_byte0, chunk_if.chunk_byte1, chunk_if.chunk_byte2,
                   chunk_if.chunk_byte3, chunk_if.byte_count, chunk_if.last_chunk,
                   chunk_if.rejected);
        end else begin
          automatic chunk_t want = chunks_due.pop_front();
          check_field("chunk_byte0", want.b0, chunk_if.chunk_byte0);
          check_field("chunk_byte1", want.b1, chunk_if.chunk_byte1);
          check_field("chunk_byte2", want.b2, chunk_if.chunk_byte2);
          check_field("chunk_byte3", want.b3, chunk_if.chunk_byte3);
          check_field("byte_count", want.count, chunk_if.byte_count);
          check_field("last_chunk", want.is_last, chunk_if.last_chunk);
          check_field("rejected", want.is_rej, chunk_if.rejected);
          chunks_checked++;
        end
      end
      chunk_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d chunks outstanding", $time, chunks_due.size());
      $display("tb_run_delta_chunk_encoder NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    gen_gray = 0;
    idle_pct = 0;
    stall_pct = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed runs, no idling
    add_run(0, 5);          // zero length, nothing out
    add_run(1, 5);          // first chunk is never a delta
    add_run(1, 8);          // delta of one pixel, single byte
    add_run(255, 8);        // zero delta, one full piece
    add_run(256, 1);        // negative delta split into two pieces
    add_run(15, 16);        // delta at the edge of the window
    add_run(15, 32);        // just outside the window
    add_run(16, 0);         // black, one length byte
    add_run(4095, 255);     // white, one length byte at its top
    add_run(4096, 100);     // literal, two length bytes
    add_run(8191, 0);       // longest run
    add_run(8192, 7);       // just too long
    add_run(16383, 255);    // largest length field
    add_run(8191, 15);      // longest delta run, most chunks
    add_run(1, 255);
    add_run(1, 0);
    add_run(2, 1);          // delta right after black
    add_run(3, 240);
    add_run(5, 255);        // white is never a delta
    add_run(7, 250);        // negative delta after white
    add_run(14'h0AAA, 8'h55);
    add_run(14'h1555, 8'hAA);
    add_run(0, 255);
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Sender mostly idle
    idle_pct = 81;
    stall_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Receiver mostly stalling
    idle_pct = 0;
    stall_pct = 81;
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Both sides idling now and then
    idle_pct = 29;
    stall_pct = 29;
    queue_random(RANDOM_PER_PHASE);
    drain();

    repeat (20) @(negedge clk);
    $display("Sent %0d runs over four idle/stall mixes; checked %0d chunks,", runs_taken,
             chunks_checked);
    $display("  %0d of them delta pieces and %0d rejected runs.", delta_chunks, rejects_due);
    if (errors == 0 && chunks_due.size() == 0) begin
      $display("tb_run_delta_chunk_encoder OK");
    end else begin
      $display("tb_run_delta_chunk_encoder NOT OK");
    end
    $finish;
  end

endmodule
